/* rtl/dictrd_pkg.sv */
package dictrd_pkg;

  // Attribute bytes at the head of every record.
  localparam int ATTRIB_BYTES = 7;
  localparam int ATTR_CNT_W   = $clog2(ATTRIB_BYTES + 1);

  // Most characters that a single input word can expand to.
  localparam int MAX_CHARS = 6;
  localparam int CNT_W     = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  localparam logic [2:0] KIND_ATTR  = 3'd0;
  localparam logic [2:0] KIND_HEAD  = 3'd1;
  localparam logic [2:0] KIND_DEF   = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_UNDER = 3'd4;

  typedef logic [7:0] char_t;

  // All characters caused by one input word, first character in slot 0.
  typedef struct packed {
    logic                    done;
    logic [2:0]              kind;
    logic [CNT_W-1:0]        cnt;
    char_t [MAX_CHARS-1:0]   chars;
  } burst_t;

endpackage

/* rtl/dictrd_if.sv */
interface dictrd_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] record_byte;
  logic       restart;

  modport source (output valid, output record_byte, output restart, input ready);
  modport sink   (input valid, input record_byte, input restart, output ready);
endinterface

interface dictrd_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [2:0] kind;
  logic       last;
  logic       record_done;

  modport source (output valid, output char_code, output kind, output last,
                  output record_done, input ready);
  modport sink   (input valid, input char_code, input kind, input last,
                  input record_done, output ready);
endinterface

/* rtl/dictrd_front.sv */
module dictrd_front import dictrd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  dictrd_in_if.sink    in_ch,
  input  logic         queue_full,
  output logic         push,
  output burst_t       burst
);

  localparam logic [2:0] PH_ATTR   = 3'd0;
  localparam logic [2:0] PH_HWLEN  = 3'd1;
  localparam logic [2:0] PH_HWLO   = 3'd2;
  localparam logic [2:0] PH_HWHI   = 3'd3;
  localparam logic [2:0] PH_DEFLEN = 3'd4;
  localparam logic [2:0] PH_DEF    = 3'd5;

  localparam char_t ESC_COMMA = 8'h7D;
  localparam char_t ESC_DOT   = 8'h7F;
  localparam char_t ESC_ELLIP = 8'hFF;
  localparam char_t ESC_FB    = 8'hFB;
  localparam char_t PAIR_EF   = 8'hEF;
  localparam char_t PAIR_F3   = 8'hF3;
  localparam char_t PAIR_FF   = 8'hFF;

  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_SEMI   = 8'h3B;

  typedef struct packed {
    logic [1:0]  cnt;
    char_t [2:0] chars;
  } half_t;

  function automatic char_t hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  function automatic char_t letter_char(input logic [4:0] v);
    char_t r;
    if (v < 5'd26) r = 8'h61 + {3'b000, v};
    else if (v == 5'd27) r = CH_SPACE;
    else if (v == 5'd30) r = 8'h27;
    else r = 8'h2A;
    return r;
  endfunction

  // Suffix strings, first character in the top byte, unused bytes zero.
  function automatic logic [23:0] suffix_chars(input logic [4:0] h);
    logic [23:0] s;
    unique case (h)
      5'd0:  s = "<0>";
      5'd1:  s = "ion";
      5'd2:  s = "ies";
      5'd3:  s = "ing";
      5'd4:  s = "ous";
      5'd5:  s = "ses";
      5'd6:  s = {"al", 8'h00};
      5'd7:  s = {"an", 8'h00};
      5'd8:  s = {"at", 8'h00};
      5'd9:  s = {"ed", 8'h00};
      5'd10: s = {"en", 8'h00};
      5'd11: s = {"er", 8'h00};
      5'd12: s = {"es", 8'h00};
      5'd13: s = {"ia", 8'h00};
      5'd14: s = {"ic", 8'h00};
      5'd15: s = {"ie", 8'h00};
      5'd16: s = {"in", 8'h00};
      5'd17: s = {"io", 8'h00};
      5'd18: s = {"is", 8'h00};
      5'd19: s = {"it", 8'h00};
      5'd20: s = {"le", 8'h00};
      5'd21: s = {"ly", 8'h00};
      5'd22: s = {"ne", 8'h00};
      5'd23: s = {"on", 8'h00};
      5'd24: s = {"or", 8'h00};
      5'd25: s = {"ra", 8'h00};
      5'd26: s = {"se", 8'h00};
      5'd27: s = {"ss", 8'h00};
      5'd28: s = {"st", 8'h00};
      5'd29: s = {"te", 8'h00};
      5'd30: s = {"ti", 8'h00};
      default: s = {"th", 8'h00};
    endcase
    return s;
  endfunction

  // A half of 32 or more is a literal, 6..31 a two-letter suffix, else three.
  function automatic half_t decode_half(input logic [6:0] h);
    half_t       r;
    logic [23:0] s;
    s = suffix_chars(h[4:0]);
    if (h >= 7'd32) begin
      r.cnt   = 2'd1;
      r.chars = '0;
      r.chars[0] = {1'b0, h};
    end else begin
      r.cnt      = (h >= 7'd6) ? 2'd2 : 2'd3;
      r.chars[0] = s[23:16];
      r.chars[1] = s[15:8];
      r.chars[2] = s[7:0];
    end
    return r;
  endfunction

  logic [2:0]            phase_r, phase_nxt;
  logic [ATTR_CNT_W-1:0] acnt_r, acnt_nxt;
  logic [7:0]            hw_rem_r, hw_rem_nxt;
  logic [7:0]            low_r, low_nxt;
  logic [7:0]            def_rem_r, def_rem_nxt;
  logic                  mask_r, mask_nxt;
  char_t                 prev_r, prev_nxt;

  logic                  accept;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && !queue_full;
  assign push        = accept && (burst.cnt != '0);

  always_comb begin
    logic [2:0]            ph;
    logic [ATTR_CNT_W-1:0] acnt;
    logic [7:0]            hwrem;
    logic [7:0]            low;
    logic [7:0]            defrem;
    logic                  mask;
    char_t                 prev;
    char_t                 b;
    char_t                 c;
    logic [ATTR_CNT_W:0]   acnt_sum;
    logic [9:0]            rem0;
    logic [9:0]            rem1;
    logic [9:0]            rem2;
    logic                  hw_end;
    half_t                 ha;
    half_t                 hb;
    logic [2:0]            na3;
    logic [2:0]            jj;
    logic [1:0]            dn;
    logic [1:0]            dd;
    char_t [2:0]           dch;

    b = in_ch.record_byte;
    // Restart applies the reset state before this byte is decoded.
    ph     = in_ch.restart ? PH_ATTR : phase_r;
    acnt   = in_ch.restart ? '0 : acnt_r;
    hwrem  = in_ch.restart ? '0 : hw_rem_r;
    low    = in_ch.restart ? '0 : low_r;
    defrem = in_ch.restart ? '0 : def_rem_r;
    mask   = in_ch.restart ? 1'b0 : mask_r;
    prev   = in_ch.restart ? '0 : prev_r;

    phase_nxt   = ph;
    acnt_nxt    = acnt;
    hw_rem_nxt  = hwrem;
    low_nxt     = low;
    def_rem_nxt = defrem;
    mask_nxt    = mask;
    prev_nxt    = prev;

    burst       = '0;
    burst.kind  = KIND_ATTR;

    acnt_sum = {1'b0, acnt} + (ATTR_CNT_W + 1)'(1);
    rem0     = {2'b00, hwrem};
    ha       = decode_half(low[6:0]);
    hb       = decode_half(b[6:0]);
    na3      = {1'b0, ha.cnt};
    rem1     = rem0 - {8'h00, ha.cnt};
    rem2     = rem1 - {8'h00, hb.cnt};
    hw_end   = 1'b0;
    c        = b ^ {mask, 7'b0000000};
    dn       = 2'd0;
    dd       = 2'd0;
    dch      = '0;
    jj       = '0;

    unique case (ph)
      PH_HWLEN: begin
        hw_rem_nxt = b;
        phase_nxt  = (b != 8'h00) ? PH_HWLO : PH_DEFLEN;
      end
      PH_HWLO: begin
        low_nxt   = b;
        phase_nxt = PH_HWHI;
      end
      PH_HWHI: begin
        burst.kind = KIND_HEAD;
        if (!b[7]) begin
          burst.cnt      = CNT_W'(3);
          burst.chars[0] = letter_char(low[4:0]);
          burst.chars[1] = letter_char({b[1:0], low[7:5]});
          burst.chars[2] = letter_char(b[6:2]);
          rem2   = rem0 - 10'd3;
          hw_end = rem2[9] || (rem2 == '0);
        end else if (rem1 == '0) begin
          // Exact end after the low half: the high half is ignored.
          burst.cnt      = CNT_W'(ha.cnt);
          burst.chars[0] = ha.chars[0];
          burst.chars[1] = ha.chars[1];
          burst.chars[2] = ha.chars[2];
          hw_end         = 1'b1;
        end else if (rem1[9]) begin
          burst.cnt  = CNT_W'(1);
          burst.kind = KIND_UNDER;
          hw_end     = 1'b1;
        end else begin
          burst.cnt = na3 + {1'b0, hb.cnt};
          for (int i = 0; i < MAX_CHARS; i++) begin
            jj = CNT_W'(i) - na3;
            if (CNT_W'(i) < na3) burst.chars[i] = ha.chars[2'(i)];
            else if (jj < 3'd3) burst.chars[i] = hb.chars[jj[1:0]];
          end
          hw_end = rem2[9] || (rem2 == '0);
        end
        if (hw_end) begin
          hw_rem_nxt = '0;
          phase_nxt  = PH_DEFLEN;
        end else begin
          hw_rem_nxt = b[7] ? rem2[7:0] : rem2[7:0];
          phase_nxt  = PH_HWLO;
        end
      end
      PH_DEFLEN: begin
        def_rem_nxt = b;
        mask_nxt    = 1'b0;
        prev_nxt    = '0;
        if (b == 8'h00) begin
          burst.cnt  = CNT_W'(1);
          burst.kind = KIND_END;
          burst.done = 1'b1;
          phase_nxt  = PH_ATTR;
        end else begin
          phase_nxt = PH_DEF;
        end
      end
      PH_DEF: begin
        mask_nxt = ~mask;
        prev_nxt = c;
        if (c == 8'h00) begin
          prev_nxt = '0;
        end else if (prev == ESC_COMMA) begin
          if (c == PAIR_EF) begin
            dch = {CH_SPACE, CH_SPACE, CH_COMMA};
            dn  = 2'd3;
            dd  = 2'd3;
          end else begin
            dch = {8'h00, c, prev};
            dn  = 2'd2;
            dd  = 2'd2;
          end
        end else if (prev == ESC_DOT) begin
          if (c == PAIR_EF) begin
            dch = {8'h00, CH_SPACE, CH_DOT};
            dn  = 2'd2;
            dd  = 2'd3;
          end
        end else if (prev == ESC_ELLIP) begin
          dd       = 2'd3;
          prev_nxt = '0;
          if (c == PAIR_F3) begin
            dch = {CH_SEMI, CH_DOT, CH_DOT};
            dn  = 2'd3;
          end else if (c == PAIR_EF) begin
            dch = {CH_SPACE, CH_DOT, CH_DOT};
            dn  = 2'd3;
          end else if (c == PAIR_FF) begin
            dch = {CH_DOT, CH_DOT, CH_DOT};
            dn  = 2'd3;
          end
        end else if (prev == ESC_FB) begin
          if (c == PAIR_FF) begin
            dch      = {8'h00, CH_DOT, CH_DOT};
            dn       = 2'd2;
            dd       = 2'd3;
            prev_nxt = '0;
          end else begin
            dch = {8'h00, c, prev};
            dn  = 2'd2;
            dd  = 2'd2;
          end
        end else if ((c == ESC_FB) || (c == ESC_ELLIP) || (c == ESC_COMMA) ||
                     (c == ESC_DOT)) begin
          // Escape lead byte: held until its partner arrives.
        end else begin
          dch = {8'h00, 8'h00, c};
          dn  = 2'd1;
          dd  = 2'd1;
        end
        burst.kind     = KIND_DEF;
        burst.cnt      = {1'b0, dn};
        burst.chars[0] = dch[0];
        burst.chars[1] = dch[1];
        burst.chars[2] = dch[2];
        rem2 = {2'b00, defrem} - {8'h00, dd};
        if (rem2[9] || (rem2 == '0)) begin
          if (dn == 2'd0) begin
            // Silent close still tells the consumer the record ended.
            burst.cnt  = CNT_W'(1);
            burst.kind = KIND_END;
          end
          burst.done  = 1'b1;
          def_rem_nxt = '0;
          phase_nxt   = PH_ATTR;
        end else begin
          def_rem_nxt = rem2[7:0];
        end
      end
      default: begin
        burst.cnt      = CNT_W'(2);
        burst.kind     = KIND_ATTR;
        burst.chars[0] = hex_char(b[7:4]);
        burst.chars[1] = hex_char(b[3:0]);
        phase_nxt      = PH_ATTR;
        if (acnt_sum >= (ATTR_CNT_W + 1)'(ATTRIB_BYTES)) begin
          acnt_nxt  = '0;
          phase_nxt = PH_HWLEN;
        end else begin
          acnt_nxt = acnt_sum[ATTR_CNT_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ATTR;
      acnt_r    <= '0;
      hw_rem_r  <= '0;
      low_r     <= '0;
      def_rem_r <= '0;
      mask_r    <= 1'b0;
      prev_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      acnt_r    <= acnt_nxt;
      hw_rem_r  <= hw_rem_nxt;
      low_r     <= low_nxt;
      def_rem_r <= def_rem_nxt;
      mask_r    <= mask_nxt;
      prev_r    <= prev_nxt;
    end
  end

  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (burst.cnt <= CNT_W'(MAX_CHARS)))
    else $error("word expanded beyond the burst size");

  a_under_single: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (burst.kind == KIND_UNDER)) |-> ((burst.cnt == CNT_W'(1)) && !burst.done))
    else $error("headword underflow must be a single result");

endmodule

/* rtl/dictrd_fifo.sv */
module dictrd_fifo import dictrd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  burst_t push_data,
  input  logic   pop,
  output burst_t head,
  output logic   head_valid,
  output logic   full
);

  burst_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W:0]   count_r;

  assign full       = (count_r == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      if (push && !pop)      count_r <= count_r + (FIFO_PTR_W + 1)'(1);
      else if (pop && !push) count_r <= count_r - (FIFO_PTR_W + 1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

/* rtl/dictrd_back.sv */
module dictrd_back import dictrd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  burst_t        head,
  input  logic          head_valid,
  output logic          pop,
  dictrd_out_if.source  out_ch
);

  logic [CNT_W-1:0] idx_r;
  logic             out_valid_r;
  char_t            char_r;
  logic [2:0]       kind_r;
  logic             last_r;
  logic             done_r;
  logic             load;
  logic             is_last;

  assign load    = head_valid && (!out_valid_r || out_ch.ready);
  assign is_last = (idx_r == (head.cnt - CNT_W'(1)));
  assign pop     = load && is_last;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.char_code   = char_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.last        = last_r;
  assign out_ch.record_done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? '0 : idx_r + CNT_W'(1);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= head.chars[idx_r];
      kind_r <= head.kind;
      last_r <= is_last;
      done_r <= is_last && head.done;
    end
  end

  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r < head.cnt))
    else $error("character index ran past the burst");

endmodule

/* rtl/dictionary_record_decoder.sv */
// Packed dictionary record decoder.
// in_ch carries one record byte per word, with restart set on the byte that
// opens a new record; any record in progress is then abandoned. out_ch
// carries one decoded character per word with its kind, a last flag on the
// final character caused by an input byte, and record_done on the word that
// closes the record.
// The front decodes a byte in the cycle it is taken and queues all of its
// characters (up to six) as one entry; the back sends them one per cycle
// while out_ch is ready. The first character of a byte passes through the
// queue memory and the back's output register on its way to out_ch. A byte
// that yields nothing (lengths, low headword bytes, escape leads) takes no
// room in the queue; otherwise its characters leave one by one, and the
// output port sets the sustained rate of one character per cycle.
// The four-entry queue lets input keep flowing while out_ch is stalled;
// in_ch.ready drops only when the queue is full. Nothing is lost when the
// receiver stalls. Reset (rst_n low, synchronous) empties the queue and
// returns the decoder to the first attribute byte of a record.
module dictionary_record_decoder import dictrd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  dictrd_in_if.sink     in_ch,
  dictrd_out_if.source  out_ch
);

  logic   push;
  logic   pop;
  logic   full;
  logic   head_valid;
  burst_t burst;
  burst_t head;

  dictrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .queue_full (full),
    .push       (push),
    .burst      (burst)
  );

  dictrd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (burst),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  dictrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
